// ===== design/nta_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nta_pkg;

   // Format selection carried by each request transaction.
   typedef enum logic [2:0] {
      OP_CHAR      = 3'd0,
      OP_UDEC      = 3'd1,
      OP_SDEC      = 3'd2,
      OP_HEX16     = 3'd3,
      OP_HEX8      = 3'd4,
      OP_HEX16_PFX = 3'd5,
      OP_HEX8_PFX  = 3'd6,
      OP_RESERVED  = 3'd7
   } opcode_type;

   // Controller states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_CR,
      S_RAW,
      S_PRE0,
      S_PREX,
      S_SIGN,
      S_CONV,
      S_SKIP,
      S_DIG,
      S_HEX
   } state_type;

   // Source of the character placed in the response register.
   typedef enum logic [2:0] {
      SEL_RAW,
      SEL_CR,
      SEL_ZERO,
      SEL_X,
      SEL_MINUS,
      SEL_HEX,
      SEL_DIGIT
   } char_sel_type;

   localparam int VALUE_W  = 64;
   localparam int NUM_BCD  = 20;
   localparam int BCD_W    = NUM_BCD * 4;
   localparam int CNT_W    = 6;

   // Counter start values: conversion bit steps, decimal digits, hex digits.
   localparam logic [CNT_W-1:0] DABBLE_INIT = 6'd63;
   localparam logic [CNT_W-1:0] DIGIT_INIT  = 6'd19;
   localparam logic [CNT_W-1:0] HEX16_INIT  = 6'd15;
   localparam logic [CNT_W-1:0] HEX8_INIT   = 6'd7;

   localparam logic [7:0] ASCII_CR    = 8'h0D;
   localparam logic [7:0] ASCII_LF    = 8'h0A;
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_X     = 8'h78;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;

   localparam logic [7:0] HEX_DIGITS [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
   };

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             load;
      logic             negate;
      logic             hex8;
      logic             cnt_load;
      logic [CNT_W-1:0] cnt_init;
      logic             dabble;
      logic             shift_hex;
      logic             dec_next;
      logic             emit;
      char_sel_type     sel;
      logic             last;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic cnt_zero;
      logic digit_zero;
      logic is_neg;
      logic is_lf;
   } status_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      return HEX_DIGITS[nibble];
   endfunction

endpackage

`default_nettype wire

// ===== design/nta_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface nta_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [63:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

// ===== design/nta_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface nta_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_out;
   logic       last;

   modport source (output valid, output char_out, output last, input ready);
   modport sink   (input valid, input char_out, input last, output ready);
endinterface

`default_nettype wire

// ===== design/nta_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nta_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [63:0]            req_value,
   input  wire nta_pkg::cmd_type       cmd,
   output nta_pkg::status_type         status,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [7:0]                  rsp_char_out,
   output logic                        rsp_last
);

   logic [nta_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [nta_pkg::BCD_W-1:0]   bcd_ff, bcd_in;
   logic [nta_pkg::BCD_W-1:0]   adj_bcd;
   logic [nta_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        out_valid_ff, out_valid_in;
   logic [7:0]                  out_char_ff, out_char_in;
   logic                        out_last_ff, out_last_in;
   logic [7:0]                  sel_char;
   logic                        out_free;

   // Add three to every BCD digit of five or more before the next shift.
   always_comb begin
      for (int d = 0; d < nta_pkg::NUM_BCD; d++) begin
         if (bcd_ff[d*4 +: 4] >= 4'd5) begin
            adj_bcd[d*4 +: 4] = bcd_ff[d*4 +: 4] + 4'd3;
         end else begin
            adj_bcd[d*4 +: 4] = bcd_ff[d*4 +: 4];
         end
      end
   end

   // Value shifter, BCD accumulator and step counter.
   always_comb begin
      value_in = value_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      if (cmd.load) begin
         bcd_in = '0;
         if (cmd.negate) begin
            value_in = ~req_value + 64'd1;
         end else if (cmd.hex8) begin
            value_in = {req_value[31:0], 32'd0};
         end else begin
            value_in = req_value;
         end
      end else if (cmd.dabble) begin
         bcd_in   = {adj_bcd[nta_pkg::BCD_W-2:0], value_ff[nta_pkg::VALUE_W-1]};
         value_in = {value_ff[nta_pkg::VALUE_W-2:0], 1'b0};
      end else if (cmd.shift_hex) begin
         value_in = {value_ff[nta_pkg::VALUE_W-5:0], 4'd0};
      end else if (cmd.dec_next) begin
         bcd_in = {bcd_ff[nta_pkg::BCD_W-5:0], 4'd0};
      end
      if (cmd.cnt_load) begin
         cnt_in = cmd.cnt_init;
      end else if (cmd.dabble || cmd.shift_hex || cmd.dec_next) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // Character selection for the response register.
   always_comb begin
      unique case (cmd.sel)
         nta_pkg::SEL_RAW:   sel_char = value_ff[7:0];
         nta_pkg::SEL_CR:    sel_char = nta_pkg::ASCII_CR;
         nta_pkg::SEL_ZERO:  sel_char = nta_pkg::ASCII_ZERO;
         nta_pkg::SEL_X:     sel_char = nta_pkg::ASCII_X;
         nta_pkg::SEL_MINUS: sel_char = nta_pkg::ASCII_MINUS;
         nta_pkg::SEL_HEX:
            sel_char = nta_pkg::hex_char(value_ff[nta_pkg::VALUE_W-1 -: 4]);
         nta_pkg::SEL_DIGIT:
            sel_char = nta_pkg::ASCII_ZERO | {4'd0, bcd_ff[nta_pkg::BCD_W-1 -: 4]};
         default:            sel_char = value_ff[7:0];
      endcase
   end

   // Response register: loads on emit, drains when the sink takes it.
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_char_in  = sel_char;
         out_last_in  = cmd.last;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         cnt_ff       <= cnt_in;
      end
      value_ff    <= value_in;
      bcd_ff      <= bcd_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign status.out_free   = out_free;
   assign status.cnt_zero   = (cnt_ff == '0);
   assign status.digit_zero = (bcd_ff[nta_pkg::BCD_W-1 -: 4] == 4'd0);
   assign status.is_neg     = req_value[nta_pkg::VALUE_W-1];
   assign status.is_lf      = (req_value[7:0] == nta_pkg::ASCII_LF);

   assign rsp_valid    = out_valid_ff;
   assign rsp_char_out = out_char_ff;
   assign rsp_last     = out_last_ff;

   // The response register is never overwritten while it holds an untaken character.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("emit while response register is occupied");

   // A conversion step never pushes a set bit out of the top digit.
   assert property (@(posedge clock) disable iff (reset)
      cmd.dabble |-> !adj_bcd[nta_pkg::BCD_W-1])
      else $error("decimal conversion overflow");

   // Digit emission only runs inside the twenty-digit window.
   assert property (@(posedge clock) disable iff (reset)
      cmd.dec_next |-> cnt_ff <= nta_pkg::DIGIT_INIT)
      else $error("digit counter out of range");

endmodule

`default_nettype wire

// ===== design/nta_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nta_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [2:0]          req_opcode,
   input  wire nta_pkg::status_type status,
   output nta_pkg::cmd_type         cmd
);

   nta_pkg::state_type  state_ff, state_in;
   nta_pkg::opcode_type op;

   assign op = nta_pkg::opcode_type'(req_opcode);

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nta_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.sel   = nta_pkg::SEL_RAW;
      unique case (state_ff)
         nta_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (op)
                  nta_pkg::OP_CHAR: begin
                     state_in = status.is_lf ? nta_pkg::S_CR : nta_pkg::S_RAW;
                  end
                  nta_pkg::OP_UDEC: begin
                     cmd.cnt_load = 1'b1;
                     cmd.cnt_init = nta_pkg::DABBLE_INIT;
                     state_in     = nta_pkg::S_CONV;
                  end
                  nta_pkg::OP_SDEC: begin
                     cmd.negate   = status.is_neg;
                     cmd.cnt_load = 1'b1;
                     cmd.cnt_init = nta_pkg::DABBLE_INIT;
                     state_in     = status.is_neg ? nta_pkg::S_SIGN : nta_pkg::S_CONV;
                  end
                  nta_pkg::OP_HEX16: begin
                     cmd.cnt_load = 1'b1;
                     cmd.cnt_init = nta_pkg::HEX16_INIT;
                     state_in     = nta_pkg::S_HEX;
                  end
                  nta_pkg::OP_HEX8: begin
                     cmd.hex8     = 1'b1;
                     cmd.cnt_load = 1'b1;
                     cmd.cnt_init = nta_pkg::HEX8_INIT;
                     state_in     = nta_pkg::S_HEX;
                  end
                  nta_pkg::OP_HEX16_PFX: begin
                     cmd.cnt_load = 1'b1;
                     cmd.cnt_init = nta_pkg::HEX16_INIT;
                     state_in     = nta_pkg::S_PRE0;
                  end
                  nta_pkg::OP_HEX8_PFX: begin
                     cmd.hex8     = 1'b1;
                     cmd.cnt_load = 1'b1;
                     cmd.cnt_init = nta_pkg::HEX8_INIT;
                     state_in     = nta_pkg::S_PRE0;
                  end
                  nta_pkg::OP_RESERVED: begin
                     // The transaction is dropped and produces no characters.
                     cmd.load = 1'b0;
                  end
                  default: cmd.load = 1'b0;
               endcase
            end
         end
         nta_pkg::S_CR: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = nta_pkg::SEL_CR;
               state_in = nta_pkg::S_RAW;
            end
         end
         nta_pkg::S_RAW: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = nta_pkg::SEL_RAW;
               cmd.last = 1'b1;
               state_in = nta_pkg::S_IDLE;
            end
         end
         nta_pkg::S_PRE0: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = nta_pkg::SEL_ZERO;
               state_in = nta_pkg::S_PREX;
            end
         end
         nta_pkg::S_PREX: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = nta_pkg::SEL_X;
               state_in = nta_pkg::S_HEX;
            end
         end
         nta_pkg::S_SIGN: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = nta_pkg::SEL_MINUS;
               state_in = nta_pkg::S_CONV;
            end
         end
         nta_pkg::S_CONV: begin
            // One binary-to-BCD step per cycle, most significant bit first.
            cmd.dabble = 1'b1;
            if (status.cnt_zero) begin
               cmd.cnt_load = 1'b1;
               cmd.cnt_init = nta_pkg::DIGIT_INIT;
               state_in     = nta_pkg::S_SKIP;
            end
         end
         nta_pkg::S_SKIP: begin
            // Drop leading zeros; the units digit always prints.
            if (!status.cnt_zero && status.digit_zero) begin
               cmd.dec_next = 1'b1;
            end else begin
               state_in = nta_pkg::S_DIG;
            end
         end
         nta_pkg::S_DIG: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.sel      = nta_pkg::SEL_DIGIT;
               cmd.dec_next = 1'b1;
               cmd.last     = status.cnt_zero;
               if (status.cnt_zero) begin
                  state_in = nta_pkg::S_IDLE;
               end
            end
         end
         nta_pkg::S_HEX: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.sel       = nta_pkg::SEL_HEX;
               cmd.shift_hex = 1'b1;
               cmd.last      = status.cnt_zero;
               if (status.cnt_zero) begin
                  state_in = nta_pkg::S_IDLE;
               end
            end
         end
         default: state_in = nta_pkg::S_IDLE;
      endcase
   end

   // The final character of a run always returns the controller to idle.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last) |=> state_ff == nta_pkg::S_IDLE)
      else $error("controller not idle after final character");

endmodule

`default_nettype wire

// ===== design/number_to_ascii_formatter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload                          Handshake
// req_chan  in         opcode[2:0], value[63:0]         valid/ready
// rsp_chan  out        char_out[7:0], last              valid/ready
//
// One request at a time; ready is high only while the controller is idle.
// Characters leave at one per cycle, while the sink is ready, through a
// single response register. Decimal output converts the value, skips up
// to 19 leading zeros and emits the digits; hex emits each digit in turn.
// Reset clears the controller and the response valid; no memory is cleared.
// A stalled response sink holds each emitting state without losing data.

module number_to_ascii_formatter_core (
   input  wire logic clock,
   input  wire logic reset,
   nta_req_if.sink   req_chan,
   nta_rsp_if.source rsp_chan
);

   nta_pkg::cmd_type    cmd;
   nta_pkg::status_type status;

   nta_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_opcode (req_chan.opcode),
      .status     (status),
      .cmd        (cmd)
   );

   nta_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_value    (req_chan.value),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .rsp_char_out (rsp_chan.char_out),
      .rsp_last     (rsp_chan.last)
   );

endmodule

`default_nettype wire

// ===== verif/tb_number_to_ascii_formatter_core.sv =====
`timescale 1ns / 1ps

module tb_number_to_ascii_formatter_core;

   // One character of formatted text and its end-of-run flag.
   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
   } text_char_type;

   localparam int          DRAIN_CYCLES = 200;
   localparam logic [7:0]  CHR_CR       = 8'h0D;
   localparam logic [7:0]  CHR_LF       = 8'h0A;
   localparam logic [7:0]  CHR_ZERO     = 8'h30;
   localparam logic [7:0]  CHR_UPPER_A  = 8'h41;
   localparam logic [7:0]  CHR_X        = 8'h78;
   localparam logic [7:0]  CHR_MINUS    = 8'h2D;

   logic clock;
   logic reset;

   nta_req_if req_if ();
   nta_rsp_if rsp_if ();

   number_to_ascii_formatter_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Characters still owed by the block, oldest first.
   text_char_type expected_text[$];
   int            error_count;
   int            burst_left;
   int            stall_cycle;
   logic [1:0]    stall_mode;

   always #4 clock = ~clock;

   // Builds the text for one accepted request and queues its characters.
   function automatic void format_item(input nta_pkg::opcode_type op,
                                       input logic [63:0] value);
      logic [7:0]  text[$];
      logic [7:0]  digits[20];
      logic [63:0] magnitude;
      logic [3:0]  nibble;
      int          count;
      int          nibbles;
      case (op)
         nta_pkg::OP_CHAR: begin
            if (value[7:0] == CHR_LF) text.push_back(CHR_CR);
            text.push_back(value[7:0]);
         end
         nta_pkg::OP_UDEC, nta_pkg::OP_SDEC: begin
            magnitude = value;
            if (op == nta_pkg::OP_SDEC && value[63]) begin
               text.push_back(CHR_MINUS);
               magnitude = ~value + 64'd1;
            end
            // Digits come out least significant first, so they are reversed.
            count = 0;
            do begin
               digits[count] = CHR_ZERO + 8'(magnitude % 64'd10);
               magnitude = magnitude / 64'd10;
               count++;
            end while (magnitude != 0);
            for (int i = count - 1; i >= 0; i--) text.push_back(digits[i]);
         end
         nta_pkg::OP_HEX16, nta_pkg::OP_HEX8, nta_pkg::OP_HEX16_PFX,
         nta_pkg::OP_HEX8_PFX: begin
            if (op == nta_pkg::OP_HEX16_PFX || op == nta_pkg::OP_HEX8_PFX) begin
               text.push_back(CHR_ZERO);
               text.push_back(CHR_X);
            end
            nibbles = (op == nta_pkg::OP_HEX16 || op == nta_pkg::OP_HEX16_PFX) ? 16 : 8;
            for (int i = nibbles - 1; i >= 0; i--) begin
               nibble = value[i*4 +: 4];
               text.push_back(nibble < 4'd10 ? CHR_ZERO + 8'(nibble)
                                             : CHR_UPPER_A + 8'(nibble - 4'd10));
            end
         end
         default: ;
      endcase
      for (int i = 0; i < text.size(); i++)
         expected_text.push_back('{char_code: text[i], last: (i == text.size() - 1)});
   endfunction

   // Random value with a spread of magnitudes and sign patterns.
   function automatic logic [63:0] random_value();
      logic [63:0] full;
      full = {$urandom, $urandom};
      case ($urandom_range(0, 6))
         0, 1:    return full;
         2:       return full >> $urandom_range(1, 63);
         3:       return 64'($urandom_range(0, 20));
         4:       return ~(full >> $urandom_range(1, 63));
         5:       return 64'h8000_0000_0000_0000 | 64'($urandom_range(0, 3));
         default: return {64{1'b1}} - 64'($urandom_range(0, 1000));
      endcase
   endfunction

   // Sends one request transaction and predicts its text once it is accepted.
   task automatic send_item(input nta_pkg::opcode_type op, input logic [63:0] value);
      req_if.valid  <= 1'b1;
      req_if.opcode <= op;
      req_if.value  <= value;
      do @(posedge clock); while (!req_if.ready);
      format_item(op, value);
      // Close the burst with an idle gap of random length.
      burst_left--;
      if (burst_left <= 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(1, 5);
      end
   endtask

   // Raw characters, including the line feed expansion and ignored upper bits.
   task automatic test_raw_characters();
      send_item(nta_pkg::OP_CHAR, 64'h0000_0000_0000_0000);
      send_item(nta_pkg::OP_CHAR, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(nta_pkg::OP_CHAR, 64'h0000_0000_0000_000A);
      send_item(nta_pkg::OP_CHAR, 64'hFFFF_FFFF_FFFF_FF0A);
   endtask

   // Unsigned decimal: zero, single digits, a power of ten and the maximum.
   task automatic test_unsigned_decimal();
      send_item(nta_pkg::OP_UDEC, 64'd0);
      send_item(nta_pkg::OP_UDEC, 64'd9);
      send_item(nta_pkg::OP_UDEC, 64'd10000000000000000000);
      send_item(nta_pkg::OP_UDEC, 64'hFFFF_FFFF_FFFF_FFFF);
   endtask

   // Signed decimal: zero, minus one, both extremes and a small negative.
   task automatic test_signed_decimal();
      send_item(nta_pkg::OP_SDEC, 64'd0);
      send_item(nta_pkg::OP_SDEC, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(nta_pkg::OP_SDEC, 64'h8000_0000_0000_0000);
      send_item(nta_pkg::OP_SDEC, 64'h7FFF_FFFF_FFFF_FFFF);
      send_item(nta_pkg::OP_SDEC, 64'hFFFF_FFFF_FFFF_FFF6);
   endtask

   // Each hex format with two of: zero, all ones, a pattern of distinct digits.
   task automatic test_hex_formats();
      send_item(nta_pkg::OP_HEX16,     64'h0123_4567_89AB_CDEF);
      send_item(nta_pkg::OP_HEX16,     64'hFFFF_FFFF_FFFF_FFFF);
      send_item(nta_pkg::OP_HEX8,      64'hFFFF_FFFF_0000_0000);
      send_item(nta_pkg::OP_HEX8,      64'h0000_0000_FEDC_BA98);
      send_item(nta_pkg::OP_HEX16_PFX, 64'd0);
      send_item(nta_pkg::OP_HEX16_PFX, 64'hFEDC_BA98_7654_3210);
      send_item(nta_pkg::OP_HEX8_PFX,  64'h0123_4567_FFFF_FFFF);
      send_item(nta_pkg::OP_HEX8_PFX,  64'd0);
   endtask

   // The unused opcode must give no characters at all.
   task automatic test_reserved_opcode();
      send_item(nta_pkg::OP_RESERVED, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(nta_pkg::OP_RESERVED, 64'h0000_0000_0000_000A);
   endtask

   // Random formats and values, with line feeds and unused opcodes mixed in.
   task automatic test_random_items(input int count);
      nta_pkg::opcode_type op;
      logic [63:0]         value;
      int                  pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 15);
         op = (pick == 15) ? nta_pkg::OP_RESERVED : nta_pkg::opcode_type'(pick % 7);
         value = random_value();
         if (op == nta_pkg::OP_CHAR && $urandom_range(0, 3) == 0) value[7:0] = CHR_LF;
         send_item(op, value);
      end
   endtask

   // Checks each response transaction and then picks the next ready value.
   always @(posedge clock) begin : rsp_check
      text_char_type wanted;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_text.size() == 0) begin
            $display("%0t: unexpected character, expected none, actual 0x%02h last %0b",
                     $time, rsp_if.char_out, rsp_if.last);
            error_count++;
         end else begin
            wanted = expected_text.pop_front();
            if (rsp_if.char_out !== wanted.char_code) begin
               $display("%0t: char_out mismatch, expected 0x%02h, actual 0x%02h",
                        $time, wanted.char_code, rsp_if.char_out);
               error_count++;
            end
            if (rsp_if.last !== wanted.last) begin
               $display("%0t: last mismatch, expected %0b, actual %0b",
                        $time, wanted.last, rsp_if.last);
               error_count++;
            end
         end
      end
      // The stall pattern is picked anew at random from four modes.
      stall_cycle++;
      if (stall_cycle % 97 == 0) stall_mode = 2'($urandom_range(0, 3));
      case (stall_mode)
         2'd0:    rsp_if.ready <= 1'b1;
         2'd1:    rsp_if.ready <= 1'($urandom_range(0, 1));
         2'd2:    rsp_if.ready <= ($urandom_range(0, 3) == 0);
         default: rsp_if.ready <= (stall_cycle % 5 != 0);
      endcase
   end

   // Main sequence: reset, directed tests, random test, drain and verdict.
   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.opcode = nta_pkg::OP_CHAR;
      req_if.value  = 64'd0;
      rsp_if.ready  = 1'b0;
      error_count   = 0;
      burst_left    = 3;
      stall_cycle   = 0;
      stall_mode    = 2'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_raw_characters();
      test_unsigned_decimal();
      test_signed_decimal();
      test_hex_formats();
      test_reserved_opcode();
      test_random_items(127);

      req_if.valid <= 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_text.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/nta_pkg.sv
design/nta_req_if.sv
design/nta_rsp_if.sv
design/nta_datapath.sv
design/nta_ctrl.sv
design/number_to_ascii_formatter_core.sv
verif/tb_number_to_ascii_formatter_core.sv
